@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define AVE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked out of reset
`define AVE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/ave_pkg.sv @@
`default_nettype none

package ave_pkg;

	// APB address width: three registers at 0x0, 0x4, 0x8
	localparam int PADDR_W = 4;

	// Register indexes
	localparam logic [1:0] REG_MIN_VALUE     = 2'd0;
	localparam logic [1:0] REG_MAX_VALUE     = 2'd1;
	localparam logic [1:0] REG_HIDDEN_DIGITS = 2'd2;

	// Request codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_POLL  = 1'b1;

	localparam logic [7:0] STEP_MAX = 8'd255;

	// Input item
	typedef struct packed {
		logic              req_type;
		logic signed [15:0] start_value;
		logic              tick;
		logic              button_up;
		logic              button_down;
		logic              button_select;
		logic              button_exit;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic signed [15:0] shown_value;
		logic              editing;
		logic              finished;
		logic signed [15:0] final_value;
	} out_item_t;

	// Configuration seen by the edit core
	typedef struct packed {
		logic signed [15:0] min_value;
		logic signed [15:0] max_value;
		logic [2:0]         hidden_digits;
		logic signed [15:0] scaled_min;
		logic signed [15:0] scaled_max;
	} ave_cfg_t;

	// 10^hidden_digits, capped at 10^4
	function automatic logic [15:0] digit_factor(input logic [2:0] hd);
		logic [15:0] f;
		case (hd)
			3'd0:    f = 16'd1;
			3'd1:    f = 16'd10;
			3'd2:    f = 16'd100;
			3'd3:    f = 16'd1000;
			default: f = 16'd10000;
		endcase
		return f;
	endfunction

	// Signed divide by 10^hidden_digits (capped at 10^4), truncating toward zero.
	// Magnitude times a reciprocal, exact for magnitudes up to 32768.
	function automatic logic signed [15:0] scale_down(input logic signed [15:0] v,
			input logic [2:0] hd);
		logic [16:0] vx;
		logic [16:0] mag;
		logic [16:0] recip;
		logic [4:0]  sh;
		logic [33:0] prod;
		logic [16:0] q;
		logic [16:0] qn;
		vx = {v[15], v};
		mag = v[15] ? 17'(~vx + 17'd1) : vx;
		case (hd)
			3'd0:    begin recip = 17'd1;     sh = 5'd0;  end
			3'd1:    begin recip = 17'd52429; sh = 5'd19; end
			3'd2:    begin recip = 17'd5243;  sh = 5'd19; end
			3'd3:    begin recip = 17'd67109; sh = 5'd26; end
			default: begin recip = 17'd53688; sh = 5'd29; end
		endcase
		prod = 34'(mag) * 34'(recip);
		q = 17'(prod >> sh);
		qn = 17'(~q + 17'd1);
		return v[15] ? $signed(qn[15:0]) : $signed(q[15:0]);
	endfunction

endpackage

`default_nettype wire

@@ rtl/ave_cfg_regs.sv @@
`default_nettype none

module ave_cfg_regs import ave_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output ave_cfg_t                cfg
);

	logic signed [15:0] min_q;
	logic signed [15:0] max_q;
	logic [2:0]         hd_q;
	logic signed [15:0] smin_q;
	logic signed [15:0] smax_q;

	logic               wr_en;
	logic [1:0]         wr_idx;
	logic signed [15:0] min_n;
	logic signed [15:0] max_n;
	logic [2:0]         hd_n;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign wr_idx = paddr[3:2];

	// Register values after this write
	always_comb begin
		min_n = min_q;
		max_n = max_q;
		hd_n  = hd_q;
		case (wr_idx)
			REG_MIN_VALUE:     min_n = $signed(pwdata[15:0]);
			REG_MAX_VALUE:     max_n = $signed(pwdata[15:0]);
			REG_HIDDEN_DIGITS: hd_n  = pwdata[2:0];
			default:           ;
		endcase
	end

	// Registers, with scaled limits kept in step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= 16'sd0;
			max_q  <= 16'sd32767;
			hd_q   <= 3'd0;
			smin_q <= 16'sd0;
			smax_q <= 16'sd32767;
		end else if (wr_en) begin
			min_q  <= min_n;
			max_q  <= max_n;
			hd_q   <= hd_n;
			smin_q <= scale_down(min_n, hd_n);
			smax_q <= scale_down(max_n, hd_n);
		end
	end

	// Read back
	always_comb begin
		case (wr_idx)
			REG_MIN_VALUE:     prdata = {{16{min_q[15]}}, min_q};
			REG_MAX_VALUE:     prdata = {{16{max_q[15]}}, max_q};
			REG_HIDDEN_DIGITS: prdata = {29'd0, hd_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg = '{min_value: min_q, max_value: max_q, hidden_digits: hd_q,
		scaled_min: smin_q, scaled_max: smax_q};

endmodule

`default_nettype wire

@@ rtl/ave_core.sv @@
`default_nettype none

module ave_core import ave_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ave_cfg_t  cfg,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	// Input stage
	logic     valid_s1;
	in_item_t item_s1;

	// Edit session state
	logic signed [15:0] orig_q;
	logic signed [15:0] cur_q;
	logic signed [15:0] smin_q;
	logic signed [15:0] smax_q;
	logic [7:0]         step_q;
	logic               active_q;

	// Result register
	logic      out_valid_q;
	out_item_t out_q;

	logic advance;

	// Next state and result
	logic signed [15:0] cur_n;
	logic signed [15:0] smin_n;
	logic signed [15:0] smax_n;
	logic signed [15:0] orig_n;
	logic [7:0]         step_n;
	logic               active_n;
	out_item_t          res;

	logic signed [15:0] v;
	logic signed [15:0] cur_up;
	logic signed [17:0] up_lim;
	logic signed [17:0] dn_lim;
	logic signed [17:0] up_dif;
	logic signed [17:0] dn_sum;
	logic [7:0]         step_t;
	logic [31:0]        fin_prod;
	logic               finish;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		cur_n    = cur_q;
		smin_n   = smin_q;
		smax_n   = smax_q;
		orig_n   = orig_q;
		step_n   = step_q;
		active_n = active_q;
		finish   = 1'b0;
		res      = '0;
		v        = $signed(item_s1.start_value);
		step_t   = step_q;
		cur_up   = cur_q;
		up_lim   = '0;
		dn_lim   = '0;
		up_dif   = '0;
		dn_sum   = '0;
		fin_prod = '0;

		if (item_s1.req_type == REQ_START) begin
			// Clamp (upper limit first) then scale down
			orig_n = v;
			if (v > cfg.max_value) begin
				cur_n = cfg.scaled_max;
			end else if (v < cfg.min_value) begin
				cur_n = cfg.scaled_min;
			end else begin
				cur_n = scale_down(v, cfg.hidden_digits);
			end
			smin_n   = cfg.scaled_min;
			smax_n   = cfg.scaled_max;
			step_n   = 8'd0;
			active_n = 1'b1;
		end else if (active_q) begin
			if (item_s1.button_up || item_s1.button_down) begin
				// Acceleration grows on ticks while a button is held
				if (item_s1.tick && step_q != STEP_MAX) begin
					step_t = step_q + 8'd1;
				end
				// Up lowers the value, clamped at the scaled minimum
				up_lim = 18'(smin_q) + $signed({10'd0, step_t});
				up_dif = 18'(cur_q) - $signed({10'd0, step_t});
				if (item_s1.button_up) begin
					cur_up = (18'(cur_q) >= up_lim) ? up_dif[15:0] : smin_q;
				end
				// Down raises the value, clamped at the scaled maximum
				dn_lim = 18'(smax_q) - $signed({10'd0, step_t});
				dn_sum = 18'(cur_up) + $signed({10'd0, step_t});
				if (item_s1.button_down) begin
					cur_n = (18'(cur_up) <= dn_lim) ? dn_sum[15:0] : smax_q;
				end else begin
					cur_n = cur_up;
				end
				step_n = step_t;
			end else if (item_s1.tick) begin
				// Idle tick decays the step
				step_n = step_q >> 2;
			end

			finish   = item_s1.button_select || item_s1.button_exit;
			fin_prod = 32'(unsigned'(cur_n)) * 32'(digit_factor(cfg.hidden_digits));
			if (item_s1.button_select) begin
				res.final_value = $signed(fin_prod[15:0]);
			end else if (item_s1.button_exit) begin
				res.final_value = orig_q;
			end
			if (finish) begin
				active_n = 1'b0;
			end
		end

		res.shown_value = cur_n;
		res.editing     = active_n;
		res.finished    = finish;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Session state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_q      <= 16'sd0;
			cur_q       <= 16'sd0;
			smin_q      <= 16'sd0;
			smax_q      <= 16'sd0;
			step_q      <= 8'd0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			orig_q      <= orig_n;
			cur_q       <= cur_n;
			smin_q      <= smin_n;
			smax_q      <= smax_n;
			step_q      <= step_n;
			active_q    <= active_n;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ rtl/accelerated_value_editor.sv @@
`default_nettype none
// Button-driven editor for a signed 16-bit setting. One item per clock is
// sustained while out_ready is high: an item is held in the input register
// and its result is then captured in the result register, raising out_valid;
// while out_ready is low, a result not yet taken stalls both registers.
// The whole update (clamp, reciprocal divide, step adjust, rescale) runs in
// the single pass between those two registers.
// Scaled limits are recomputed at each register write over APB; pready is
// always high. A start item returns editing=1; a poll item with select or
// exit during a session returns finished=1 and the returned setting in final_value.

`include "assert_macros.svh"

module accelerated_value_editor import ave_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire in_item_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output out_item_t               out_data
);

	ave_cfg_t cfg;

	ave_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ave_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// A finishing item always closes the session
	`AVE_ASSERT_IMP(a_fin_closes, clk, arst_n, out_valid && out_data.finished, !out_data.editing)
	// No returned setting unless the session finished
	`AVE_ASSERT_IMP(a_final_zero, clk, arst_n, out_valid && !out_data.finished, out_data.final_value == 16'sd0)
	// An empty result register never stalls the input
	`AVE_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid, in_ready)
	// A result not taken is still offered next cycle
	`AVE_ASSERT_NXT(a_out_held, clk, arst_n, out_valid && !out_ready, out_valid)

endmodule

`default_nettype wire

@@ tb/accelerated_value_editor_tb.sv @@
`timescale 1ns / 1ps

module accelerated_value_editor_tb;
	import ave_pkg::*;

	localparam int CYCLE_LIMIT = 250000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 270;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_item_t           in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_data;

	accelerated_value_editor uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Editor state as the testbench sees it
	logic signed [15:0] cfg_min = 16'sd0;
	logic signed [15:0] cfg_max = 16'sd32767;
	logic [2:0]         cfg_digits = 3'd0;
	logic signed [15:0] ed_orig = '0;
	logic signed [15:0] ed_cur = '0;
	logic signed [15:0] ed_smin = '0;
	logic signed [15:0] ed_smax = '0;
	logic [7:0]         ed_step = '0;
	logic               ed_active = 1'b0;

	in_item_t  pending[$];
	out_item_t result_q[$];

	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_sessions = 0;
	int n_finished = 0;
	int n_step_peaks = 0;
	int n_err = 0;
	int cycle_count = 0;

	int drv_max_gap = 5;
	int rcv_max_stall = 5;
	int idle_left = 0;
	int stall_left = 0;
	int stall_next = 0;
	int hold_left = 0;
	int hold_asks = 0;
	int hold_done = 0;

	function automatic int decade_scale(input logic [2:0] digits);
		case (digits)
			3'd0:    return 1;
			3'd1:    return 10;
			3'd2:    return 100;
			3'd3:    return 1000;
			default: return 10000;
		endcase
	endfunction

	// Apply one item to the editor state and return the result it should produce
	function automatic out_item_t edit_step(input in_item_t it);
		out_item_t r;
		int        v;
		int        f;
		r = '0;
		f = decade_scale(cfg_digits);
		if (it.req_type == REQ_START) begin
			v = int'(it.start_value);
			ed_orig = it.start_value;
			// upper limit tested first, so with min > max a value above max lands on max, any other on min
			if (v > int'(cfg_max)) begin
				v = int'(cfg_max);
			end else if (v < int'(cfg_min)) begin
				v = int'(cfg_min);
			end
			ed_cur = 16'(v / f);
			ed_smin = 16'(int'(cfg_min) / f);
			ed_smax = 16'(int'(cfg_max) / f);
			ed_step = '0;
			ed_active = 1'b1;
			n_sessions++;
		end else if (ed_active) begin
			if (it.button_up || it.button_down) begin
				if (it.tick && ed_step < STEP_MAX) begin
					ed_step = ed_step + 8'd1;
					if (ed_step == STEP_MAX) n_step_peaks++;
				end
				// up lowers, down raises; both clamp without wrapping
				if (it.button_up) begin
					if (int'(ed_cur) >= int'(ed_smin) + int'(ed_step))
						ed_cur = 16'(int'(ed_cur) - int'(ed_step));
					else
						ed_cur = ed_smin;
				end
				if (it.button_down) begin
					if (int'(ed_cur) <= int'(ed_smax) - int'(ed_step))
						ed_cur = 16'(int'(ed_cur) + int'(ed_step));
					else
						ed_cur = ed_smax;
				end
			end else if (it.tick) begin
				ed_step = ed_step >> 2;
			end
			if (it.button_select) begin
				r.final_value = 16'(int'(ed_cur) * f);
				r.finished = 1'b1;
				ed_active = 1'b0;
			end else if (it.button_exit) begin
				r.final_value = ed_orig;
				r.finished = 1'b1;
				ed_active = 1'b0;
			end
		end
		r.shown_value = ed_cur;
		r.editing = ed_active;
		return r;
	endfunction

	function automatic in_item_t start_item(input logic signed [15:0] v);
		in_item_t it;
		it = '0;
		it.req_type = REQ_START;
		it.start_value = v;
		return it;
	endfunction

	function automatic in_item_t poll_item(input logic t, input logic u, input logic d,
			input logic s, input logic e);
		in_item_t it;
		it = '0;
		it.req_type = REQ_POLL;
		it.start_value = 16'($urandom);
		it.tick = t;
		it.button_up = u;
		it.button_down = d;
		it.button_select = s;
		it.button_exit = e;
		return it;
	endfunction

	task automatic queue_item(input in_item_t it);
		pending.push_back(it);
		n_queued++;
	endtask

	// APB write: setup cycle, then access cycle
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MIN_VALUE:     cfg_min = data[15:0];
			REG_MAX_VALUE:     cfg_max = data[15:0];
			REG_HIDDEN_DIGITS: cfg_digits = data[2:0];
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic signed [15:0] lo, input logic signed [15:0] hi,
			input logic [2:0] digits);
		reg_write(REG_MIN_VALUE, {{16{lo[15]}}, lo});
		reg_write(REG_MAX_VALUE, {{16{hi[15]}}, hi});
		reg_write(REG_HIDDEN_DIGITS, 32'(digits));
	endtask

	// Sender pauses until every expected result is back
	task automatic drain;
		while (pending.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Driver: offers pending items, predicts each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			idle_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				result_q.push_back(edit_step(in_data));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (idle_left != 0) begin
					idle_left <= idle_left - 1;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					in_data <= pending.pop_front();
					in_valid <= 1'b1;
					idle_left <= $urandom_range(0, drv_max_gap);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result, stalls per item, and takes long holds on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			stall_next = stall_left;
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result item arrived with none expected");
					n_err++;
				end else begin
					out_item_t want;
					want = result_q.pop_front();
					if (out_data.shown_value !== want.shown_value) begin
						$error("shown_value: expected %0d, got %0d",
							want.shown_value, out_data.shown_value);
						n_err++;
					end
					if (out_data.editing !== want.editing) begin
						$error("editing: expected %0b, got %0b", want.editing, out_data.editing);
						n_err++;
					end
					if (out_data.finished !== want.finished) begin
						$error("finished: expected %0b, got %0b",
							want.finished, out_data.finished);
						n_err++;
					end
					if (out_data.final_value !== want.final_value) begin
						$error("final_value: expected %0d, got %0d",
							want.final_value, out_data.final_value);
						n_err++;
					end
					n_checked++;
					if (want.finished) n_finished++;
				end
				stall_next = $urandom_range(0, rcv_max_stall);
			end
			if (hold_asks != hold_done) begin
				hold_done <= hold_done + 1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (stall_next != 0) begin
				stall_next = stall_next - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			stall_left <= stall_next;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("accelerated_value_editor test failed");
			$finish;
		end
	end

	initial begin
		in_item_t           it;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic [2:0]         digits;
		int                 target;
		int                 len;
		int                 kind;
		logic               u;
		logic               d;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at reset limits [0, 32767], no hidden digits
		queue_item(poll_item(1, 1, 1, 1, 1));       // poll with no session
		queue_item(start_item(16'sd32767));
		queue_item(start_item(16'sh8000));          // below min, clamps to 0
		it = start_item(16'sd100);
		it.tick = 1'b1;
		it.button_up = 1'b1;
		it.button_down = 1'b1;
		it.button_select = 1'b1;
		it.button_exit = 1'b1;
		queue_item(it);                             // flags ignored on start
		queue_item(poll_item(1, 1, 0, 0, 0));
		queue_item(poll_item(1, 0, 1, 0, 0));
		queue_item(poll_item(1, 1, 1, 0, 0));       // one tick, then up, then down
		queue_item(poll_item(1, 0, 0, 0, 0));       // step decays
		queue_item(poll_item(0, 0, 0, 0, 0));
		queue_item(poll_item(0, 0, 1, 0, 0));       // zero step
		queue_item(poll_item(0, 0, 0, 1, 1));       // select beats exit
		queue_item(poll_item(0, 1, 0, 0, 0));       // after the session
		queue_item(start_item(-16'sd5));
		queue_item(poll_item(1, 1, 0, 0, 0));       // pinned at min
		queue_item(poll_item(0, 0, 0, 0, 1));       // exit gives the unclamped start
		queue_item(start_item(16'sd32767));
		queue_item(poll_item(1, 0, 1, 0, 0));       // pinned at max
		queue_item(poll_item(1, 1, 0, 0, 1));       // buttons applied before exit
		drain();

		// Widest digit scaling at the extreme limits
		set_limits(16'sh8000, 16'sd32767, 3'd4);
		queue_item(start_item(16'sh8000));
		queue_item(poll_item(0, 0, 0, 1, 0));
		queue_item(start_item(16'sd32767));
		queue_item(poll_item(1, 0, 1, 1, 0));
		queue_item(start_item(16'sd12345));
		queue_item(poll_item(0, 0, 0, 0, 1));
		drain();

		// Random phases, each under its own limits, one of them with no gaps or stalls
		for (int p = 0; p < 6; p++) begin
			drv_max_gap = 5;
			rcv_max_stall = 5;
			case (p)
				0: begin lo = 16'sh8000; hi = 16'sd32767; digits = 3'd0; end
				1: begin lo = -16'sd500; hi = 16'sd1200; digits = 3'd2; end
				2: begin lo = 16'sd32767; hi = 16'sh8000; digits = 3'd4; end
				3: begin
					lo = 16'sh8000; hi = 16'sd32767; digits = 3'd3;
					drv_max_gap = 0;
					rcv_max_stall = 0;
				end
				4: begin lo = -16'sd9; hi = 16'sd9; digits = 3'd1; end
				default: begin
					lo = 16'($urandom);
					hi = 16'($urandom);
					digits = 3'($urandom_range(0, 4));
				end
			endcase
			set_limits(lo, hi, digits);
			target = n_queued + PHASE_ITEMS;
			while (n_queued < target) begin
				kind = $urandom_range(0, 19);
				if (kind == 0) begin
					it = in_item_t'(22'($urandom));     // raw noise
					queue_item(it);
				end else if (kind == 1) begin
					queue_item(poll_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1))));
				end else begin
					// a well-formed session: start, button traffic, then mostly a finish
					case ($urandom_range(0, 5))
						0: it = start_item(16'sh8000);
						1: it = start_item(16'sd32767);
						2: it = start_item(16'(int'(cfg_min) + $urandom_range(0, 20) - 10));
						3: it = start_item(16'(int'(cfg_max) + $urandom_range(0, 20) - 10));
						default: it = start_item(16'($urandom));
					endcase
					queue_item(it);
					if ($urandom_range(0, 14) == 0) begin
						// long hold that drives the step toward saturation
						len = $urandom_range(260, 300);
						u = 1'($urandom_range(0, 1));
						for (int i = 0; i < len; i++) begin
							d = ($urandom_range(0, 7) == 0) ? u : ~u;
							queue_item(poll_item($urandom_range(0, 9) != 0, u, d, 0, 0));
						end
					end else begin
						len = $urandom_range(1, 20);
						for (int i = 0; i < len; i++) begin
							queue_item(poll_item(1'($urandom_range(0, 1)),
								$urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
								$urandom_range(0, 39) == 0, $urandom_range(0, 39) == 0));
						end
					end
					if ($urandom_range(0, 7) != 0) begin
						queue_item(poll_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1) ^
							in_item_t'(22'($urandom_range(0, 1) << 1)));
					end
				end
			end
			// first phase: receiver holds off while the sender keeps offering
			if (p == 0) hold_asks++;
			drain();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d items and %0d results over %0d edit sessions",
			n_accepted, n_checked, n_sessions);
		$display("%0d sessions finished, step saturated %0d times, eight register settings",
			n_finished, n_step_peaks);
		if (n_err == 0) begin
			$display("accelerated_value_editor test passed");
		end else begin
			$display("accelerated_value_editor test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ave_pkg.sv
rtl/ave_cfg_regs.sv
rtl/ave_core.sv
rtl/accelerated_value_editor.sv
tb/accelerated_value_editor_tb.sv
